@@ rtl/mixed_fraction_alu_core_assert.svh @@
// ----------------------------------------------------------------------------
// mixed fraction alu assertion macros
// shorthand for clocked assertions used by the core
// ----------------------------------------------------------------------------
`ifndef MIXED_FRACTION_ALU_CORE_ASSERT_SVH
`define MIXED_FRACTION_ALU_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MFA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MFA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfa_pkg
// shared types and constants of the mixed fraction alu
// ----------------------------------------------------------------------------
package mfa_pkg;

   localparam int MFA_OPERAND_WIDTH_DEF = 16;
   localparam int MFA_DW                = 64;   // internal datapath, wraps mod 2^64
   localparam int MFA_CNT_W             = $clog2(MFA_DW);
   localparam int MFA_WHOLE_W           = 61;
   localparam int MFA_WIDE_W            = 46;

   typedef enum logic [1:0] {
      MFA_OP_ADD = 2'd0,
      MFA_OP_SUB = 2'd1,
      MFA_OP_MUL = 2'd2,
      MFA_OP_DIV = 2'd3
   } mfa_op_type;

   typedef enum logic [1:0] {
      MFA_ERR_NONE     = 2'd0,
      MFA_ERR_ZERO_DEN = 2'd1,
      MFA_ERR_DIV_ZERO = 2'd2
   } mfa_err_type;

   // operations of the shared arithmetic unit
   typedef enum logic [1:0] {
      MFA_UOP_MUL = 2'd0,
      MFA_UOP_DIV = 2'd1,
      MFA_UOP_GCD = 2'd2
   } mfa_uop_type;

   typedef struct packed {
      logic        start;
      mfa_uop_type uop;
   } mfa_cmd_type;

endpackage

@@ rtl/mfa_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfa_unit
// shared iterative unit: shift-add multiply, restoring divide, binary gcd
// ----------------------------------------------------------------------------
module mfa_unit
   import mfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mfa_cmd_type       cmd,
   input  logic [MFA_DW-1:0] opnd_x,
   input  logic [MFA_DW-1:0] opnd_y,
   output logic              done,
   output logic [MFA_DW-1:0] res_q,
   output logic [MFA_DW-1:0] res_r
);

   typedef enum logic [1:0] {
      U_IDLE = 2'b01,
      U_RUN  = 2'b10
   } ustate_type;

   ustate_type           ust_ff, ust_in;
   mfa_uop_type          uop_ff, uop_in;
   logic [MFA_DW-1:0]    a_ff, a_in;
   logic [MFA_DW-1:0]    b_ff, b_in;
   logic [MFA_DW-1:0]    r_ff, r_in;
   logic [MFA_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [MFA_DW-1:0]    q_ff, q_in;
   logic [MFA_DW-1:0]    rr_ff, rr_in;

   logic [MFA_DW:0]      r_sh;
   logic                 u_ge;
   logic [MFA_DW:0]      add_a, add_b;
   logic                 add_cin;
   logic [MFA_DW+1:0]    sum;
   logic                 carry;

   assign r_sh = {r_ff, a_ff[MFA_DW-1]};
   assign u_ge = (a_ff >= b_ff);

   // the one wide adder
   always_comb begin
      unique case (uop_ff)
         MFA_UOP_MUL: begin
            add_a   = {1'b0, r_ff};
            add_b   = {1'b0, a_ff};
            add_cin = 1'b0;
         end
         MFA_UOP_DIV: begin
            add_a   = r_sh;
            add_b   = ~{1'b0, b_ff};
            add_cin = 1'b1;
         end
         MFA_UOP_GCD: begin
            add_a   = {1'b0, (u_ge ? a_ff : b_ff)};
            add_b   = ~{1'b0, (u_ge ? b_ff : a_ff)};
            add_cin = 1'b1;
         end
         default: begin
            add_a   = '0;
            add_b   = '0;
            add_cin = 1'b0;
         end
      endcase
   end

   assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{(MFA_DW+1){1'b0}}, add_cin};
   assign carry = sum[MFA_DW+1];

   always_comb begin
      ust_in  = ust_ff;
      uop_in  = uop_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      rr_in   = rr_ff;
      unique case (ust_ff)
         U_IDLE: begin
            if (cmd.start) begin
               uop_in = cmd.uop;
               a_in   = opnd_x;
               b_in   = opnd_y;
               r_in   = '0;
               cnt_in = '0;
               ust_in = U_RUN;
            end
         end
         U_RUN: begin
            unique case (uop_ff)
               MFA_UOP_MUL: begin
                  // a is the shifting multiplicand, b the multiplier, r the sum
                  if (b_ff == '0) begin
                     q_in    = r_ff;
                     done_in = 1'b1;
                     ust_in  = U_IDLE;
                  end else begin
                     if (b_ff[0]) r_in = sum[MFA_DW-1:0];
                     a_in = a_ff << 1;
                     b_in = b_ff >> 1;
                  end
               end
               MFA_UOP_DIV: begin
                  // one quotient bit per clock
                  r_in   = carry ? sum[MFA_DW-1:0] : r_sh[MFA_DW-1:0];
                  a_in   = {a_ff[MFA_DW-2:0], carry};
                  cnt_in = cnt_ff + MFA_CNT_W'(1);
                  if (cnt_ff == '1) begin
                     q_in    = {a_ff[MFA_DW-2:0], carry};
                     rr_in   = carry ? sum[MFA_DW-1:0] : r_sh[MFA_DW-1:0];
                     done_in = 1'b1;
                     ust_in  = U_IDLE;
                  end
               end
               MFA_UOP_GCD: begin
                  // binary gcd, cnt holds the common power of two
                  priority if (a_ff == '0) begin
                     q_in    = b_ff << cnt_ff;
                     done_in = 1'b1;
                     ust_in  = U_IDLE;
                  end else if (b_ff == '0) begin
                     q_in    = a_ff << cnt_ff;
                     done_in = 1'b1;
                     ust_in  = U_IDLE;
                  end else if (!a_ff[0] && !b_ff[0]) begin
                     a_in   = a_ff >> 1;
                     b_in   = b_ff >> 1;
                     cnt_in = cnt_ff + MFA_CNT_W'(1);
                  end else if (!a_ff[0]) begin
                     a_in = a_ff >> 1;
                  end else if (!b_ff[0]) begin
                     b_in = b_ff >> 1;
                  end else if (u_ge) begin
                     a_in = sum[MFA_DW-1:0] >> 1;
                  end else begin
                     b_in = sum[MFA_DW-1:0] >> 1;
                  end
               end
               default: begin
                  ust_in = U_IDLE;
               end
            endcase
         end
         default: begin
            ust_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ust_ff  <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         ust_ff  <= ust_in;
         done_ff <= done_in;
      end
      uop_ff <= uop_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rr_ff  <= rr_in;
   end

   assign done  = done_ff;
   assign res_q = q_ff;
   assign res_r = rr_ff;

endmodule

@@ rtl/mixed_fraction_alu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_fraction_alu_core
// exact add, subtract, multiply and divide of two mixed numbers
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; busy then stays high
// until the result is out (it stays low for a zero operand denominator). the
// result appears on the rsp_ ports for exactly one clock with rsp_valid high
// and cannot be held off, so capture it in that cycle. each operand is turned
// into an improper fraction, combined, reduced by the gcd and returned as floor
// whole part, fraction numerator and denominator. each request runs four or
// five shift-add multiplies, a binary gcd and three restoring divides, all on
// one shared unit that retires one bit or one gcd step per clock. a zero
// operand denominator is answered on the clock right after the request is
// taken, and a divisor of zero value once both operand multiplies are done.
// ----------------------------------------------------------------------------
`include "mixed_fraction_alu_core_assert.svh"

module mixed_fraction_alu_core
   import mfa_pkg::*;
#(
   parameter int OPERAND_WIDTH = MFA_OPERAND_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_whole,
   input  logic [OPERAND_WIDTH-2:0]      req_a_frac,
   input  logic [OPERAND_WIDTH-2:0]      req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_whole,
   input  logic [OPERAND_WIDTH-2:0]      req_b_frac,
   input  logic [OPERAND_WIDTH-2:0]      req_b_den,
   output logic                          rsp_valid,
   output logic signed [MFA_WHOLE_W-1:0] rsp_res_whole,
   output logic [MFA_WIDE_W-1:0]         rsp_res_frac,
   output logic [MFA_WIDE_W-1:0]         rsp_res_den,
   output logic [1:0]                    rsp_error
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = OPERAND_WIDTH - 1;
   localparam int DW = MFA_DW;

   // sequencer, one state per use of the shared unit, plus idle and the combining step
   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_MUL_A   = 11'b000_0000_0010,  // |a_whole| * a_den
      S_MUL_B   = 11'b000_0000_0100,  // |b_whole| * b_den
      S_MUL_T1  = 11'b000_0000_1000,  // ma * b_den, or ma * mb
      S_MUL_T2  = 11'b000_0001_0000,  // mb * a_den
      S_MUL_DEN = 11'b000_0010_0000,  // b_den * a_den
      S_COMBINE = 11'b000_0100_0000,  // signed sum and zero checks
      S_GCD     = 11'b000_1000_0000,
      S_DIV_MAG = 11'b001_0000_0000,
      S_DIV_DEN = 11'b010_0000_0000,
      S_DIV_RES = 11'b100_0000_0000   // whole part and remainder
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic                 start_ff, start_in;

   // request capture
   mfa_op_type           op_ff, op_in;
   logic [W-1:0]         aw_ff, aw_in, bw_ff, bw_in;
   logic [PW-1:0]        af_ff, af_in, ad_ff, ad_in;
   logic [PW-1:0]        bf_ff, bf_in, bd_ff, bd_in;

   // working values, sign and magnitude
   logic [DW-1:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic                 sa_ff, sa_in, sb_ff, sb_in;
   logic [DW-1:0]        t1_ff, t1_in, t2_ff, t2_in;
   logic [DW-1:0]        den_ff, den_in, g_ff, g_in;
   logic                 neg_ff, neg_in;

   // result registers
   logic                 valid_ff, valid_in;
   logic [MFA_WHOLE_W-1:0] whole_ff, whole_in;
   logic [MFA_WIDE_W-1:0]  frac_ff, frac_in;
   logic [MFA_WIDE_W-1:0]  rden_ff, rden_in;
   mfa_err_type          err_ff, err_in;

   // shared unit hookup
   mfa_cmd_type          u_cmd;
   logic [DW-1:0]        u_x, u_y;
   logic                 u_done;
   logic [DW-1:0]        u_q, u_r;

   logic                 accept;

   // operand magnitudes and zero-extended fields
   logic                 a_wneg, b_wneg;
   logic [W-1:0]         a_wmag, b_wmag;
   logic [DW-1:0]        a_wmag_x, b_wmag_x, ad_x, bd_x, af_x, bf_x;

   // improper numerator fixup after a whole-part product
   logic                 imp_wneg, imp_ge, imp_cin, imp_neg;
   logic [DW-1:0]        imp_frac, imp_opa, imp_opb, imp_mag;

   // combining step
   logic                 sb_eff, same_sign, t_ge, sm_cin, sm_sign;
   logic [DW-1:0]        sm_opa, sm_opb, sm_mag;
   logic [DW-1:0]        comb_mag, comb_den;
   logic                 comb_neg;

   // floor fixup on the final quotient
   logic [DW-1:0]        fl_whole, fl_frac;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign a_wneg   = aw_ff[W-1];
   assign b_wneg   = bw_ff[W-1];
   assign a_wmag   = a_wneg ? (~aw_ff + W'(1)) : aw_ff;
   assign b_wmag   = b_wneg ? (~bw_ff + W'(1)) : bw_ff;
   assign a_wmag_x = {{(DW-W){1'b0}}, a_wmag};
   assign b_wmag_x = {{(DW-W){1'b0}}, b_wmag};
   assign ad_x     = {{(DW-PW){1'b0}}, ad_ff};
   assign bd_x     = {{(DW-PW){1'b0}}, bd_ff};
   assign af_x     = {{(DW-PW){1'b0}}, af_ff};
   assign bf_x     = {{(DW-PW){1'b0}}, bf_ff};

   // whole*den + frac, with a negative whole part pulling the fraction back
   always_comb begin
      imp_wneg = (state_ff == S_MUL_A) ? a_wneg : b_wneg;
      imp_frac = (state_ff == S_MUL_A) ? af_x : bf_x;
      imp_ge   = (u_q >= imp_frac);
      if (!imp_wneg) begin
         imp_opa = u_q;
         imp_opb = imp_frac;
         imp_cin = 1'b0;
      end else if (imp_ge) begin
         imp_opa = u_q;
         imp_opb = ~imp_frac;
         imp_cin = 1'b1;
      end else begin
         imp_opa = imp_frac;
         imp_opb = ~u_q;
         imp_cin = 1'b1;
      end
      imp_mag = imp_opa + imp_opb + {{(DW-1){1'b0}}, imp_cin};
      imp_neg = imp_wneg && imp_ge && (u_q != imp_frac);
   end

   // signed add of the cross products, or product/quotient sign
   always_comb begin
      sb_eff    = (op_ff == MFA_OP_SUB) ? !sb_ff : sb_ff;
      same_sign = (sa_ff == sb_eff);
      t_ge      = (t1_ff >= t2_ff);
      if (same_sign) begin
         sm_opa = t1_ff;
         sm_opb = t2_ff;
         sm_cin = 1'b0;
      end else if (t_ge) begin
         sm_opa = t1_ff;
         sm_opb = ~t2_ff;
         sm_cin = 1'b1;
      end else begin
         sm_opa = t2_ff;
         sm_opb = ~t1_ff;
         sm_cin = 1'b1;
      end
      sm_mag  = sm_opa + sm_opb + {{(DW-1){1'b0}}, sm_cin};
      sm_sign = (same_sign || t_ge) ? sa_ff : sb_eff;
      unique case (op_ff)
         MFA_OP_ADD, MFA_OP_SUB: begin
            comb_mag = sm_mag;
            comb_neg = (sm_mag != '0) && sm_sign;
            comb_den = den_ff;
         end
         MFA_OP_MUL: begin
            comb_mag = t1_ff;
            comb_neg = (t1_ff != '0) && (sa_ff != sb_ff);
            comb_den = den_ff;
         end
         MFA_OP_DIV: begin
            comb_mag = t1_ff;
            comb_neg = (t1_ff != '0) && (sa_ff != sb_ff);
            comb_den = t2_ff;
         end
         default: begin
            comb_mag = '0;
            comb_neg = 1'b0;
            comb_den = '0;
         end
      endcase
   end

   // floor whole part, fraction kept non-negative
   always_comb begin
      if (!neg_ff) begin
         fl_whole = u_q;
         fl_frac  = u_r;
      end else if (u_r == '0) begin
         fl_whole = ~u_q + DW'(1);
         fl_frac  = '0;
      end else begin
         fl_whole = ~u_q;
         fl_frac  = den_ff - u_r;
      end
   end

   // operand select for the shared unit
   always_comb begin
      u_cmd.start = start_ff;
      u_cmd.uop   = MFA_UOP_MUL;
      u_x         = '0;
      u_y         = '0;
      unique case (state_ff)
         S_MUL_A: begin
            u_x = a_wmag_x;
            u_y = ad_x;
         end
         S_MUL_B: begin
            u_x = b_wmag_x;
            u_y = bd_x;
         end
         S_MUL_T1: begin
            u_x = ma_ff;
            u_y = (op_ff == MFA_OP_MUL) ? mb_ff : bd_x;
         end
         S_MUL_T2: begin
            u_x = mb_ff;
            u_y = ad_x;
         end
         S_MUL_DEN: begin
            u_x = bd_x;
            u_y = ad_x;
         end
         S_GCD: begin
            u_cmd.uop = MFA_UOP_GCD;
            u_x       = t1_ff;
            u_y       = den_ff;
         end
         S_DIV_MAG: begin
            u_cmd.uop = MFA_UOP_DIV;
            u_x       = t1_ff;
            u_y       = g_ff;
         end
         S_DIV_DEN: begin
            u_cmd.uop = MFA_UOP_DIV;
            u_x       = den_ff;
            u_y       = g_ff;
         end
         S_DIV_RES: begin
            u_cmd.uop = MFA_UOP_DIV;
            u_x       = t1_ff;
            u_y       = den_ff;
         end
         default: begin
            u_cmd.uop = MFA_UOP_MUL;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      op_in    = op_ff;
      aw_in    = aw_ff;
      af_in    = af_ff;
      ad_in    = ad_ff;
      bw_in    = bw_ff;
      bf_in    = bf_ff;
      bd_in    = bd_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      den_in   = den_ff;
      g_in     = g_ff;
      neg_in   = neg_ff;
      valid_in = 1'b0;
      whole_in = whole_ff;
      frac_in  = frac_ff;
      rden_in  = rden_ff;
      err_in   = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = mfa_op_type'(req_op);
               aw_in = $unsigned(req_a_whole);
               af_in = req_a_frac;
               ad_in = req_a_den;
               bw_in = $unsigned(req_b_whole);
               bf_in = req_b_frac;
               bd_in = req_b_den;
               if (req_a_den == '0 || req_b_den == '0) begin
                  // zero operand denominator, answered at once
                  valid_in = 1'b1;
                  whole_in = '0;
                  frac_in  = '0;
                  rden_in  = '0;
                  err_in   = MFA_ERR_ZERO_DEN;
               end else begin
                  state_in = S_MUL_A;
                  start_in = 1'b1;
               end
            end
         end
         S_MUL_A: begin
            if (u_done) begin
               ma_in    = imp_mag;
               sa_in    = imp_neg;
               state_in = S_MUL_B;
               start_in = 1'b1;
            end
         end
         S_MUL_B: begin
            if (u_done) begin
               mb_in = imp_mag;
               sb_in = imp_neg;
               if (op_ff == MFA_OP_DIV && imp_mag == '0) begin
                  // divisor value is zero
                  valid_in = 1'b1;
                  whole_in = '0;
                  frac_in  = '0;
                  rden_in  = '0;
                  err_in   = MFA_ERR_DIV_ZERO;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_MUL_T1;
                  start_in = 1'b1;
               end
            end
         end
         S_MUL_T1: begin
            if (u_done) begin
               t1_in    = u_q;
               state_in = (op_ff == MFA_OP_MUL) ? S_MUL_DEN : S_MUL_T2;
               start_in = 1'b1;
            end
         end
         S_MUL_T2: begin
            if (u_done) begin
               t2_in = u_q;
               if (op_ff == MFA_OP_DIV) begin
                  state_in = S_COMBINE;
               end else begin
                  state_in = S_MUL_DEN;
                  start_in = 1'b1;
               end
            end
         end
         S_MUL_DEN: begin
            if (u_done) begin
               den_in   = u_q;
               state_in = S_COMBINE;
            end
         end
         S_COMBINE: begin
            if (comb_den == '0) begin
               // denominator wrapped to zero at wide operand widths
               valid_in = 1'b1;
               whole_in = '0;
               frac_in  = '0;
               rden_in  = '0;
               err_in   = MFA_ERR_DIV_ZERO;
               state_in = S_IDLE;
            end else begin
               t1_in    = comb_mag;
               den_in   = comb_den;
               neg_in   = comb_neg;
               state_in = S_GCD;
               start_in = 1'b1;
            end
         end
         S_GCD: begin
            if (u_done) begin
               g_in     = u_q;
               state_in = S_DIV_MAG;
               start_in = 1'b1;
            end
         end
         S_DIV_MAG: begin
            if (u_done) begin
               t1_in    = u_q;
               state_in = S_DIV_DEN;
               start_in = 1'b1;
            end
         end
         S_DIV_DEN: begin
            if (u_done) begin
               den_in   = u_q;
               state_in = S_DIV_RES;
               start_in = 1'b1;
            end
         end
         S_DIV_RES: begin
            if (u_done) begin
               valid_in = 1'b1;
               whole_in = fl_whole[MFA_WHOLE_W-1:0];
               frac_in  = fl_frac[MFA_WIDE_W-1:0];
               rden_in  = den_ff[MFA_WIDE_W-1:0];
               err_in   = MFA_ERR_NONE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         valid_ff <= valid_in;
      end
      op_ff    <= op_in;
      aw_ff    <= aw_in;
      af_ff    <= af_in;
      ad_ff    <= ad_in;
      bw_ff    <= bw_in;
      bf_ff    <= bf_in;
      bd_ff    <= bd_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      den_ff   <= den_in;
      g_ff     <= g_in;
      neg_ff   <= neg_in;
      whole_ff <= whole_in;
      frac_ff  <= frac_in;
      rden_ff  <= rden_in;
      err_ff   <= err_in;
   end

   // shared multiply / divide / gcd unit
   mfa_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (u_cmd),
      .opnd_x (u_x),
      .opnd_y (u_y),
      .done   (u_done),
      .res_q  (u_q),
      .res_r  (u_r)
   );

   assign rsp_valid     = valid_ff;
   assign rsp_res_whole = $signed(whole_ff);
   assign rsp_res_frac  = frac_ff;
   assign rsp_res_den   = rden_ff;
   assign rsp_error     = err_ff;

   // an accepted request keeps the block busy or is answered on the next clock
   `MFA_ASSERT_NXT(a_accept_busy, start && !busy, busy || rsp_valid, "request accepted but dropped")

   // a result is only shown once the sequencer is back in idle
   `MFA_ASSERT_IMP(a_valid_idle, rsp_valid, !busy, "result shown while busy")

   // error results carry all-zero payload
   `MFA_ASSERT_IMP(a_err_zero, rsp_valid && (rsp_error != MFA_ERR_NONE),
      (rsp_res_whole == '0) && (rsp_res_frac == '0) && (rsp_res_den == '0),
      "error result with nonzero payload")

endmodule
